[sv/matrix3_inverse_defines.svh]
// ---------------------------------------------------------------------------
// matrix3_inverse assertion macros
// shared property templates for the inverse block checks
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MINV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix3_inverse check failed");

// next-cycle implication, disabled in reset
`define MINV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix3_inverse check failed");

`endif

[sv/minv_pkg.sv]
// ---------------------------------------------------------------------------
// minv_pkg
// widths, word types and pipeline constants of the 3x3 inverse
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package minv_pkg;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int COF_W      = PROD_W + 1;
  localparam int DETP_W     = ELEM_W + COF_W;
  localparam int DET_W      = DETP_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int FRAC_SHIFT = 24;
  localparam int NUM_W      = MAG_W + FRAC_SHIFT;
  localparam int DVS_W      = 48;
  localparam int OUT_W      = 32;
  localparam int Q_W        = OUT_W + 1;
  localparam int OVF_SHIFT  = Q_W - FRAC_SHIFT;
  localparam int PRE_STAGES = 5;
  localparam int LATENCY    = PRE_STAGES + Q_W + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef cof_t [8:0]               cof_vec_t;
  typedef elem_t [2:0]              row_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv00;
    logic signed [OUT_W-1:0] inv01;
    logic signed [OUT_W-1:0] inv02;
    logic signed [OUT_W-1:0] inv10;
    logic signed [OUT_W-1:0] inv11;
    logic signed [OUT_W-1:0] inv12;
    logic signed [OUT_W-1:0] inv20;
    logic signed [OUT_W-1:0] inv21;
    logic signed [OUT_W-1:0] inv22;
    logic                    singular;
  } out_t;

  // one divider lane's operands
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef lane_t [8:0] lane_vec_t;

endpackage

[sv/matrix3_inverse.sv]
// Throughput: one matrix per cycle; busy stays low, every cycle can take a word.
// Depth is set by the divider: one quotient bit per stage over 33 bits,
// after five stages of products, cofactors, determinant and operand prep, plus the output register.
// Reset clears the valid bits only; data registers run free.
// ---------------------------------------------------------------------------
// matrix3_inverse
// pipelined 3x3 inverse by adjugate over determinant, Q8.8 in, Q16.16 out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3_inverse_defines.svh"
module matrix3_inverse
  import minv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_word,
  output logic out_strobe,
  output out_t out_word
);

  localparam logic [Q_W-1:0]   POS_LIM = Q_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic [Q_W-1:0]   NEG_LIM = Q_W'({1'b1, {(OUT_W-1){1'b0}}});
  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic             accept;
  logic [LATENCY-1:0] v_r;
  logic [Q_W-1:0]   sing_r;
  cof_vec_t         cof;
  row_t             row0;
  lane_vec_t        lanes;
  logic [DVS_W-1:0] dvs;
  logic             singular;
  logic [Q_W-1:0]   quo [9];
  logic             neg [9];
  logic             ovf [9];
  logic [OUT_W-1:0] res [9];
  out_t             out_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  minv_cofactor u_cof (
    .clk     (clk),
    .in_word (in_word),
    .cof     (cof),
    .row0    (row0)
  );

  minv_det u_det (
    .clk      (clk),
    .cof      (cof),
    .row0     (row0),
    .lanes    (lanes),
    .dvs      (dvs),
    .singular (singular)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    minv_div_lane u_div (
      .clk  (clk),
      .lane (lanes[k]),
      .dvs  (dvs),
      .quo  (quo[k]),
      .neg  (neg[k]),
      .ovf  (ovf[k])
    );

    // zero on singular, else sign and saturate the quotient magnitude
    always_comb begin
      logic [Q_W-1:0] qn;
      qn = -quo[k];
      if (sing_r[Q_W-1]) begin
        res[k] = '0;
      end else if (neg[k]) begin
        res[k] = (ovf[k] || quo[k] > NEG_LIM) ? SAT_MIN : qn[OUT_W-1:0];
      end else begin
        res[k] = (ovf[k] || quo[k] > POS_LIM) ? SAT_MAX : quo[k][OUT_W-1:0];
      end
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LATENCY-2:0], accept};
    end
  end

  // singular flag follows the divider stages
  always_ff @(posedge clk) begin
    sing_r <= {sing_r[Q_W-2:0], singular};
  end

  // output register
  always_ff @(posedge clk) begin
    out_r <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
              sing_r[Q_W-1]};
  end

  assign out_strobe = v_r[LATENCY-1];
  assign out_word   = out_r;

  // checks
  `MINV_ASSERT_NEXT(a_enter, clk, rst_n, accept, v_r[0])
  `MINV_ASSERT_IMPL(a_origin, clk, rst_n, out_strobe, $past(accept, LATENCY))
  `MINV_ASSERT_IMPL(a_sing_zero, clk, rst_n, out_strobe && out_r.singular, out_r[9*OUT_W:1] == '0)

endmodule

[sv/minv_cofactor.sv]
// ---------------------------------------------------------------------------
// minv_cofactor
// two stages: eighteen element products, then the nine cofactor differences
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module minv_cofactor
  import minv_pkg::*;
(
  input  logic     clk,
  input  in_t      in_word,
  output cof_vec_t cof,
  output row_t     row0
);

  logic signed [PROD_W-1:0] p_r [18];
  row_t     row0_s1_r, row0_r;
  cof_vec_t cof_r;

  // stage 1: products, pairs ordered as (plus, minus) per cofactor
  always_ff @(posedge clk) begin
    p_r[0]  <= in_word.m11 * in_word.m22;  p_r[1]  <= in_word.m12 * in_word.m21;
    p_r[2]  <= in_word.m02 * in_word.m21;  p_r[3]  <= in_word.m01 * in_word.m22;
    p_r[4]  <= in_word.m01 * in_word.m12;  p_r[5]  <= in_word.m02 * in_word.m11;
    p_r[6]  <= in_word.m12 * in_word.m20;  p_r[7]  <= in_word.m10 * in_word.m22;
    p_r[8]  <= in_word.m00 * in_word.m22;  p_r[9]  <= in_word.m02 * in_word.m20;
    p_r[10] <= in_word.m02 * in_word.m10;  p_r[11] <= in_word.m00 * in_word.m12;
    p_r[12] <= in_word.m10 * in_word.m21;  p_r[13] <= in_word.m11 * in_word.m20;
    p_r[14] <= in_word.m01 * in_word.m20;  p_r[15] <= in_word.m00 * in_word.m21;
    p_r[16] <= in_word.m00 * in_word.m11;  p_r[17] <= in_word.m01 * in_word.m10;
    row0_s1_r <= {in_word.m02, in_word.m01, in_word.m00};
  end

  // stage 2: cofactor differences
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      cof_r[k] <= COF_W'(p_r[2*k]) - COF_W'(p_r[2*k+1]);
    end
    row0_r <= row0_s1_r;
  end

  assign cof  = cof_r;
  assign row0 = row0_r;

endmodule

[sv/minv_det.sv]
// ---------------------------------------------------------------------------
// minv_det
// three stages: determinant products, determinant sum, divider operand prep
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module minv_det
  import minv_pkg::*;
(
  input  logic             clk,
  input  cof_vec_t         cof,
  input  row_t             row0,
  output lane_vec_t        lanes,
  output logic [DVS_W-1:0] dvs,
  output logic             singular
);

  logic signed [DETP_W-1:0] dp_r [3];
  logic signed [DET_W-1:0]  det_r;
  cof_vec_t                 cof_s3_r, cof_s4_r;
  lane_vec_t                lanes_r;
  logic [DVS_W-1:0]         dvs_r;
  logic                     singular_r;
  logic [DET_W-1:0]         det_abs;
  logic [DVS_W-1:0]         det_mag;

  // stage 3: first row times its cofactors
  always_ff @(posedge clk) begin
    dp_r[0]  <= $signed(row0[0]) * $signed(cof[0]);
    dp_r[1]  <= $signed(row0[1]) * $signed(cof[3]);
    dp_r[2]  <= $signed(row0[2]) * $signed(cof[6]);
    cof_s3_r <= cof;
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    det_r    <= DET_W'(dp_r[0]) + DET_W'(dp_r[1]) + DET_W'(dp_r[2]);
    cof_s4_r <= cof_s3_r;
  end

  assign det_abs = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign det_mag = det_abs[DVS_W-1:0];

  // stage 5: magnitudes, signs, the quotient overflow check, divisor and singular flag
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      logic [COF_W-1:0] ca;
      logic [MAG_W-1:0] cm;
      ca = cof_s4_r[k][COF_W-1] ? COF_W'(-cof_s4_r[k]) : COF_W'(cof_s4_r[k]);
      cm = ca[MAG_W-1:0];
      lanes_r[k].num <= {cm, {FRAC_SHIFT{1'b0}}};
      lanes_r[k].neg <= cof_s4_r[k][COF_W-1] ^ det_r[DET_W-1];
      lanes_r[k].ovf <= DVS_W'(cm >> OVF_SHIFT) >= det_mag;
    end
    dvs_r      <= det_mag;
    singular_r <= (det_r == '0);
  end

  assign lanes    = lanes_r;
  assign dvs      = dvs_r;
  assign singular = singular_r;

endmodule

[sv/minv_div_lane.sv]
// ---------------------------------------------------------------------------
// minv_div_lane
// restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module minv_div_lane
  import minv_pkg::*;
(
  input  logic             clk,
  input  lane_t            lane,
  input  logic [DVS_W-1:0] dvs,
  output logic [Q_W-1:0]   quo,
  output logic             neg,
  output logic             ovf
);

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DVS_W-1:0] d_r   [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic             neg_r [Q_W];
  logic             ovf_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int BIT = Q_W - 1 - s;
    logic [NUM_W-1:0] rem_prev, rem_nxt, d_ext;
    logic [DVS_W-1:0] d_prev;
    logic [Q_W-1:0]   q_prev, q_nxt;
    logic             neg_prev, ovf_prev, take;

    if (s == 0) begin : g_first
      assign rem_prev = lane.num;
      assign d_prev   = dvs;
      assign q_prev   = '0;
      assign neg_prev = lane.neg;
      assign ovf_prev = lane.ovf;
    end else begin : g_next
      assign rem_prev = rem_r[s-1];
      assign d_prev   = d_r[s-1];
      assign q_prev   = q_r[s-1];
      assign neg_prev = neg_r[s-1];
      assign ovf_prev = ovf_r[s-1];
    end

    // trial subtract of the divisor at this bit weight
    always_comb begin
      d_ext   = NUM_W'(d_prev);
      take    = (rem_prev >> BIT) >= d_ext;
      rem_nxt = take ? rem_prev - (d_ext << BIT) : rem_prev;
      q_nxt   = q_prev;
      q_nxt[BIT] = take;
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      d_r[s]   <= d_prev;
      q_r[s]   <= q_nxt;
      neg_r[s] <= neg_prev;
      ovf_r[s] <= ovf_prev;
    end
  end

  assign quo = q_r[Q_W-1];
  assign neg = neg_r[Q_W-1];
  assign ovf = ovf_r[Q_W-1];

endmodule
